/* src/hpq_pkg.sv */
// hpq_pkg: shared types and codes for the min-heap priority queue
// depends on nothing; imported by hpq_mem, hpq_ctrl and min_heap_priority_queue
`default_nettype none

package hpq_pkg;

  localparam int PRIO_W  = 16;
  localparam int TAG_W   = 32;
  localparam int COUNT_W = 7;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_PEEK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } hpq_entry_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  tag;
  } hpq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [TAG_W-1:0]   removed_tag;
    logic [PRIO_W-1:0]  removed_priority;
    logic               head_valid;
    logic [TAG_W-1:0]   head_tag;
    logic [PRIO_W-1:0]  head_priority;
    logic [COUNT_W-1:0] count;
  } hpq_rsp_t;

endpackage

`default_nettype wire

/* src/min_heap_priority_queue.sv */
// min_heap_priority_queue: binary min-heap priority queue top level
// depends on hpq_pkg, hpq_mem and hpq_ctrl
//
// usage: drive request (action, priority_req, tag) with start high; the request
// is taken at a clock edge where start is high and busy is low, and busy stays
// high until it is finished. each request gives one result, marked by done for
// exactly one cycle; the receiver cannot stall it and must capture it then.
// steps of each request:
//   peek or refused request: no heap work; the head is read for the result
//   insert: the new entry is written at the end and sifted up
//   remove-min: the root and the last entry are read; unless that empties the
//   queue, the last entry sifts down from the root
//   update: a scan for the tag; when found, a sift up with the new priority,
//   a second scan for the moved entry and a sift down from where it lies
// every step goes through the single read port of the entry store, one read
// issued per cycle with registered read data; that port paces each request.
// busy drops as done rises, so the next request can be taken at the edge that
// ends the result cycle; one request is in flight at a time.
// reset (rst, synchronous) empties the queue; the store itself is not cleared.
`default_nettype none

module min_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire hpq_req_t request,
  output logic          busy,
  output logic          done,
  output hpq_rsp_t      result
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  hpq_entry_t       mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  hpq_entry_t       mem_rdata;
  logic             rsp_valid;
  hpq_rsp_t         rsp;

  hpq_mem #(
    .DEPTH (CAPACITY),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  hpq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rsp_valid;
    end
    if (rsp_valid) begin
      result <= rsp;
    end
  end

endmodule

`default_nettype wire

/* src/hpq_mem.sv */
// hpq_mem: heap entry store, one write port and one registered read port
// depends on hpq_pkg for the entry type
`default_nettype none

module hpq_mem
  import hpq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic       clk,
  input  wire logic       we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire hpq_entry_t wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output hpq_entry_t      rdata
);

  hpq_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/hpq_ctrl.sv */
// hpq_ctrl: sequencer for insert, remove-min, update and peek over the heap store
// depends on hpq_pkg; drives the ports of hpq_mem
`default_nettype none

module hpq_ctrl
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 64,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire hpq_req_t   request,
  output logic            busy,
  output logic            rsp_valid,
  output hpq_rsp_t        rsp,
  output logic            mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output hpq_entry_t      mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  wire hpq_entry_t mem_rdata
);

  localparam int EXT_W = IDX_W + 2;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_REM_ROOT = 11'b000_0000_0010,
    S_REM_LAST = 11'b000_0000_0100,
    S_UP_RD    = 11'b000_0000_1000,
    S_UP_CMP   = 11'b000_0001_0000,
    S_DN_RDL   = 11'b000_0010_0000,
    S_DN_RDR   = 11'b000_0100_0000,
    S_DN_CMP   = 11'b000_1000_0000,
    S_SCAN     = 11'b001_0000_0000,
    S_HEAD_RD  = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [1:0]         op;
  logic [1:0]         status;
  hpq_entry_t         cur;
  hpq_entry_t         lval;
  hpq_entry_t         removed;
  logic [IDX_W-1:0]   pos;
  logic               has_r;
  logic [CNT_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   scan_pos;
  logic               scan_v;
  logic               pass2;
  logic [PRIO_W-1:0]  req_prio;
  logic [TAG_W-1:0]   req_tag;

  logic [IDX_W-1:0]   parent;
  logic [EXT_W-1:0]   l_ext;
  logic [EXT_W-1:0]   r_ext;
  logic [EXT_W-1:0]   count_ext;
  logic [IDX_W-1:0]   l_idx;
  logic [IDX_W-1:0]   r_idx;
  logic               l_in;
  logic               parent_gt;
  logic               pick_l;
  logic               pick_r;
  logic [PRIO_W-1:0]  best_prio;
  logic               scan_match;
  logic               scan_last;

  always_comb begin
    parent    = (pos - IDX_W'(1)) >> 1;
    l_ext     = {1'b0, pos, 1'b1};
    r_ext     = l_ext + EXT_W'(1);
    count_ext = EXT_W'(count);
    l_idx     = l_ext[IDX_W-1:0];
    r_idx     = r_ext[IDX_W-1:0];
    l_in      = l_ext < count_ext;
    parent_gt = mem_rdata.prio > cur.prio;
    // strict compares: a child only wins when it is smaller
    pick_l    = lval.prio < cur.prio;
    best_prio = pick_l ? lval.prio : cur.prio;
    pick_r    = has_r && (mem_rdata.prio < best_prio);
    scan_match = pass2 ? (mem_rdata == cur) : (mem_rdata.tag == req_tag);
    scan_last  = CNT_W'(scan_pos) == (count - CNT_W'(1));
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = cur;
    mem_raddr = '0;
    case (state)
      S_REM_ROOT: mem_raddr = IDX_W'(count - CNT_W'(1));
      S_UP_RD: begin
        mem_raddr = parent;
        mem_we    = (pos == '0);
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = parent_gt ? mem_rdata : cur;
      end
      S_DN_RDL: begin
        mem_raddr = l_idx;
        mem_we    = !l_in;
      end
      S_DN_RDR: mem_raddr = r_idx;
      S_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = pick_r ? mem_rdata : (pick_l ? lval : cur);
      end
      S_SCAN: mem_raddr = scan_idx[IDX_W-1:0];
      default: mem_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op       <= request.action;
            req_prio <= request.priority_req;
            req_tag  <= request.tag;
            removed  <= '0;
            status   <= ST_OK;
            state    <= S_HEAD_RD;
            case (request.action)
              ACT_INSERT: begin
                if (count == CNT_W'(CAPACITY)) begin
                  status <= ST_FULL;
                end else begin
                  cur   <= '{prio: request.priority_req, tag: request.tag};
                  pos   <= IDX_W'(count);
                  count <= count + CNT_W'(1);
                  state <= S_UP_RD;
                end
              end
              ACT_REMOVE: begin
                if (count == '0) status <= ST_EMPTY;
                else             state  <= S_REM_ROOT;
              end
              ACT_UPDATE: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  scan_idx <= '0;
                  scan_v   <= 1'b0;
                  pass2    <= 1'b0;
                  state    <= S_SCAN;
                end
              end
              default: begin
                if (count == '0) status <= ST_EMPTY;
              end
            endcase
          end
        end
        S_REM_ROOT: begin
          removed <= mem_rdata;
          count   <= count - CNT_W'(1);
          state   <= S_REM_LAST;
        end
        S_REM_LAST: begin
          if (count == '0) begin
            state <= S_HEAD_RD;
          end else begin
            cur   <= mem_rdata;
            pos   <= '0;
            state <= S_DN_RDL;
          end
        end
        S_UP_RD: begin
          if (pos == '0) begin
            if (op == ACT_UPDATE) begin
              scan_idx <= '0;
              scan_v   <= 1'b0;
              pass2    <= 1'b1;
              state    <= S_SCAN;
            end else begin
              state <= S_HEAD_RD;
            end
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (parent_gt) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else if (op == ACT_UPDATE) begin
            // locate the first matching entry again before sifting down
            scan_idx <= '0;
            scan_v   <= 1'b0;
            pass2    <= 1'b1;
            state    <= S_SCAN;
          end else begin
            state <= S_HEAD_RD;
          end
        end
        S_DN_RDL: begin
          state <= l_in ? S_DN_RDR : S_HEAD_RD;
        end
        S_DN_RDR: begin
          lval  <= mem_rdata;
          has_r <= r_ext < count_ext;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (pick_r) begin
            pos   <= r_idx;
            state <= S_DN_RDL;
          end else if (pick_l) begin
            pos   <= l_idx;
            state <= S_DN_RDL;
          end else begin
            state <= S_HEAD_RD;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + CNT_W'(1);
          scan_pos <= scan_idx[IDX_W-1:0];
          scan_v   <= 1'b1;
          if (scan_v) begin
            if (scan_match) begin
              pos <= scan_pos;
              if (pass2) begin
                state <= S_DN_RDL;
              end else begin
                cur   <= '{prio: req_prio, tag: mem_rdata.tag};
                state <= S_UP_RD;
              end
            end else if (scan_last) begin
              if (!pass2) status <= ST_NOT_FOUND;
              state <= S_HEAD_RD;
            end
          end
        end
        S_HEAD_RD: state <= S_DONE;
        S_DONE:    state <= S_IDLE;
        default:   state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    busy      = state != S_IDLE;
    rsp_valid = state == S_DONE;
    rsp.status           = status;
    rsp.removed_tag      = removed.tag;
    rsp.removed_priority = removed.prio;
    rsp.head_valid       = count != '0;
    rsp.head_tag         = (count != '0) ? mem_rdata.tag  : '0;
    rsp.head_priority    = (count != '0) ? mem_rdata.prio : '0;
    rsp.count            = COUNT_W'(count);
  end

endmodule

`default_nettype wire
